/* rtl/dkef_pkg.sv */
// Package for the delete-key escape filter.
// Holds the byte constants, the matcher state type and the decoded-request struct.
// Depends on nothing; used by every module of the block.
package dkef_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] CSI_BYTE   = 8'h5B;
  localparam logic [7:0] THREE_BYTE = 8'h33;
  localparam logic [7:0] TILDE_BYTE = 8'h7E;
  localparam logic [7:0] DEL_BYTE   = 8'h7F;
  localparam logic [7:0] BS_BYTE    = 8'h08;

  // Most results one request can cause, and the widths that follow from it.
  localparam int MAX_BEATS = 4;
  localparam int CNT_W     = $clog2(MAX_BEATS + 1);
  localparam int POS_W     = $clog2(MAX_BEATS);

  typedef logic [MAX_BEATS-1:0][7:0] beat_arr_t;

  // Bytes replayed when a partial match breaks, in order.
  localparam beat_arr_t PREFIX_BYTES = {8'h00, THREE_BYTE, CSI_BYTE, ESC_BYTE};

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ESC  = 2'd1,
    ST_CSI  = 2'd2,
    ST_CSI3 = 2'd3
  } esc_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    beat_arr_t        beats;
    esc_state_t       next_state;
  } dkef_res_t;

endpackage

/* rtl/dkef_decode.sv */
// Escape matcher: decodes one request against the current matcher state.
// Gives the next state and the burst of result bytes. Uses dkef_pkg.
module dkef_decode import dkef_pkg::*; (
  input  esc_state_t  state,
  input  logic [7:0]  rx_byte,
  output dkef_res_t   res
);

  esc_state_t       idle_next;
  esc_state_t       state_next;
  logic [POS_W-1:0] rep;
  logic             tail;
  logic [7:0]       tail_byte;
  logic [7:0]       mapped;

  assign idle_next = (rx_byte == ESC_BYTE) ? ST_ESC : ST_IDLE;
  assign mapped    = (rx_byte == BS_BYTE || rx_byte == DEL_BYTE) ? DEL_BYTE : rx_byte;

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = idle_next;
      ST_ESC:  state_next = (rx_byte == CSI_BYTE) ? ST_CSI : idle_next;
      ST_CSI:  state_next = (rx_byte == THREE_BYTE) ? ST_CSI3 : idle_next;
      ST_CSI3: state_next = (rx_byte == TILDE_BYTE) ? ST_IDLE : idle_next;
      default: state_next = ST_IDLE;
    endcase
  end

  // rep is the number of held bytes replayed; tail says whether a result follows
  // them: the byte itself handled from idle, or the delete of a whole sequence.
  always_comb begin
    rep       = '0;
    tail      = (rx_byte != ESC_BYTE);
    tail_byte = mapped;
    unique case (state)
      ST_IDLE: begin
        rep = '0;
      end
      ST_ESC: begin
        if (rx_byte == CSI_BYTE) begin
          tail = 1'b0;
        end else begin
          rep = POS_W'(1);
        end
      end
      ST_CSI: begin
        if (rx_byte == THREE_BYTE) begin
          tail = 1'b0;
        end else begin
          rep = POS_W'(2);
        end
      end
      ST_CSI3: begin
        if (rx_byte == TILDE_BYTE) begin
          tail      = 1'b1;
          tail_byte = DEL_BYTE;
        end else begin
          rep = POS_W'(3);
        end
      end
      default: begin
        rep = '0;
      end
    endcase
  end

  always_comb begin
    res.next_state = state_next;
    res.cnt        = CNT_W'(rep) + CNT_W'(tail);
    for (int i = 0; i < MAX_BEATS; i++) begin
      res.beats[i] = (POS_W'(i) < rep) ? PREFIX_BYTES[i] : tail_byte;
    end
  end

endmodule

/* rtl/dkef_burst.sv */
// Result register: holds the bytes of one request and hands them out in order.
// Reports when it can take a new burst in the same cycle. Uses dkef_pkg.
module dkef_burst import dkef_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [CNT_W-1:0] load_cnt,
  input  beat_arr_t        load_beats,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             last
);

  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] rem_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  beat_arr_t        beats;
  logic             pop;

  assign out_valid = (rem != '0);
  assign last      = (rem == CNT_W'(1));
  assign out_byte  = beats[pos];
  assign pop       = out_valid && out_ready;
  // Free when empty, or when the final byte of the burst leaves this cycle.
  assign free      = !out_valid || (pop && last);

  always_comb begin
    rem_next = rem;
    pos_next = pos;
    if (load) begin
      rem_next = load_cnt;
      pos_next = '0;
    end else if (pop) begin
      rem_next = rem - CNT_W'(1);
      pos_next = pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      pos <= '0;
    end else begin
      rem <= rem_next;
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beats <= load_beats;
    end
  end

endmodule

/* rtl/delete_key_escape_filter.sv */
// Top level of the delete-key escape filter: input register, matcher, result register.
// Depends on dkef_pkg, dkef_decode and dkef_burst.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------
//   input   | in_valid / in_ready   | rx_byte
//   output  | out_valid / out_ready | out_byte, last
//
// A request is captured in the input register, then decoded and loaded into the result
// register, which drives its first result. The result register gives one result byte per
// cycle while out_ready is high; a request causes one to four results, and a prefix byte
// causes none but still passes through the input register.
// Reset clears the input and result registers and puts the matcher in idle.
// A stalled output holds its byte; the input register fills and then in_ready drops.
module delete_key_escape_filter import dkef_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  esc_state_t escape_state;
  dkef_res_t  dec;
  logic       free;
  logic       hold_move;
  logic       load;

  dkef_decode u_decode (
    .state   (escape_state),
    .rx_byte (hold_byte),
    .res     (dec)
  );

  // A request that yields nothing leaves without waiting for the result register.
  assign hold_move = hold_valid && (free || dec.cnt == '0);
  assign load      = hold_move && (dec.cnt != '0);
  assign in_ready  = !hold_valid || hold_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      escape_state <= ST_IDLE;
    end else begin
      if (in_ready) begin
        hold_valid <= in_valid;
      end
      if (hold_move) begin
        escape_state <= dec.next_state;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= rx_byte;
    end
  end

  dkef_burst u_burst (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .load_cnt   (dec.cnt),
    .load_beats (dec.beats),
    .free       (free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last       (last)
  );

  a_state_only_on_move: assert property (@(posedge clk) disable iff (rst)
    !hold_move |=> escape_state == $past(escape_state))
    else $error("matcher state changed without a request leaving");

  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !hold_move |=> hold_valid && hold_byte == $past(hold_byte))
    else $error("held request lost or changed while stalled");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> (escape_state == ST_IDLE && !out_valid && !hold_valid))
    else $error("block not clean after reset");

endmodule

/* dv/dkef_stream_checker.sv */
// Checker for the delete-key escape filter: watches both channels and predicts each result.
// Keeps its own copy of the escape matcher and compares every result against it.
// Depends on dkef_pkg for the byte constants and the matcher state type.
module dkef_stream_checker import dkef_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       last,
  output int         fail_count,
  output int         pending_count,
  output int         results_checked,
  output int         deletes_seen
);

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } filtered_byte_t;

  esc_state_t     matcher_state;
  filtered_byte_t expected_bytes[$];

  initial begin
    fail_count      = 0;
    pending_count   = 0;
    results_checked = 0;
    deletes_seen    = 0;
    matcher_state   = ST_IDLE;
  end

  // Works out the bytes that one request yields and queues them in order.
  task automatic filter_delete_key(input logic [7:0] c);
    logic [7:0]     burst[$];
    filtered_byte_t item;
    case (matcher_state)
      ST_ESC: begin
        if (c == CSI_BYTE) begin
          matcher_state = ST_CSI;
          return;
        end
        burst.push_back(ESC_BYTE);
      end
      ST_CSI: begin
        if (c == THREE_BYTE) begin
          matcher_state = ST_CSI3;
          return;
        end
        burst.push_back(ESC_BYTE);
        burst.push_back(CSI_BYTE);
      end
      ST_CSI3: begin
        if (c == TILDE_BYTE) begin
          matcher_state = ST_IDLE;
          deletes_seen++;
          item.data = DEL_BYTE;
          item.fin  = 1'b1;
          expected_bytes.push_back(item);
          return;
        end
        burst.push_back(ESC_BYTE);
        burst.push_back(CSI_BYTE);
        burst.push_back(THREE_BYTE);
      end
      default: ;
    endcase

    // The breaking byte is then taken as if the matcher were idle.
    if (c == ESC_BYTE) begin
      matcher_state = ST_ESC;
    end else begin
      matcher_state = ST_IDLE;
      burst.push_back((c == BS_BYTE || c == DEL_BYTE) ? DEL_BYTE : c);
    end

    foreach (burst[i]) begin
      item.data = burst[i];
      item.fin  = (i == burst.size() - 1);
      expected_bytes.push_back(item);
    end
  endtask

  always @(posedge clk) begin
    filtered_byte_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        filter_delete_key(rx_byte);
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result: expected none, got byte %h last %b",
                   $time, out_byte, last);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte mismatch: expected %h, got %h",
                     $time, want.data, out_byte);
            fail_count++;
          end
          if (last !== want.fin) begin
            $display("%0t: last mismatch on byte %h: expected %b, got %b",
                     $time, want.data, want.fin, last);
            fail_count++;
          end
        end
      end
      pending_count = expected_bytes.size();
    end
  end

endmodule

/* dv/delete_key_escape_filter_tb.sv */
// Testbench top for the delete-key escape filter: clock, reset, stimulus and verdict.
// Sends directed and random console bytes with bursty input and a stalling receiver.
// Depends on dkef_pkg, delete_key_escape_filter and dkef_stream_checker.
module delete_key_escape_filter_tb import dkef_pkg::*;;

  localparam int RANDOM_REQUESTS = 500;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_CYCLES     = 200;
  localparam logic [7:0] DELETE_SEQ [4] = '{ESC_BYTE, CSI_BYTE, THREE_BYTE, TILDE_BYTE};

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       last;

  int fail_count;
  int pending_count;
  int results_checked;
  int deletes_seen;

  int sent_count    = 0;
  int burst_left    = 1;
  int cycle_count   = 0;
  bit long_hold_req = 1'b0;

  delete_key_escape_filter DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .last     (last)
  );

  dkef_stream_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last           (last),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .results_checked(results_checked),
    .deletes_seen   (deletes_seen)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one request and holds it until accepted; the sender works in bursts.
  task automatic offer_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Leans towards the bytes that the matcher treats specially.
  function automatic logic [7:0] pick_console_byte();
    case ($urandom_range(0, 9))
      0:       return ESC_BYTE;
      1:       return BS_BYTE;
      2:       return DEL_BYTE;
      3:       return TILDE_BYTE;
      4:       return CSI_BYTE;
      5:       return THREE_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: stretches of steady, random or sparse readiness, plus one long hold-off.
  initial begin
    int stretch;
    int mode;
    bit hold_done;
    hold_done = 1'b0;
    @(negedge rst);
    forever begin
      stretch = $urandom_range(20, 80);
      mode    = $urandom_range(0, 2);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        for (int i = 0; i < stretch; i++) begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= (i % 4 == 3);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    int target;
    int pick;
    int depth;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Field extremes, backspace and delete mapping, then every way a match can end.
    offer_byte(8'h00);
    offer_byte(8'hFF);
    offer_byte(8'h41);
    offer_byte(BS_BYTE);
    offer_byte(DEL_BYTE);
    for (int i = 0; i < 4; i++) offer_byte(DELETE_SEQ[i]);
    offer_byte(ESC_BYTE);
    offer_byte(8'h61);
    // A second ESC replays the first and keeps the matcher after ESC.
    offer_byte(ESC_BYTE);
    offer_byte(ESC_BYTE);
    offer_byte(CSI_BYTE);
    offer_byte(THREE_BYTE);
    offer_byte(TILDE_BYTE);
    offer_byte(ESC_BYTE);
    offer_byte(CSI_BYTE);
    offer_byte(DEL_BYTE);
    offer_byte(ESC_BYTE);
    offer_byte(CSI_BYTE);
    offer_byte(THREE_BYTE);
    offer_byte(ESC_BYTE);
    offer_byte(BS_BYTE);

    long_hold_req = 1'b1;
    target = sent_count + RANDOM_REQUESTS;
    while (sent_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        for (int i = 0; i < 4; i++) offer_byte(DELETE_SEQ[i]);
      end else if (pick < 65) begin
        depth = $urandom_range(1, 3);
        for (int i = 0; i < depth; i++) offer_byte(DELETE_SEQ[i]);
        offer_byte(pick_console_byte());
      end else begin
        offer_byte(pick_console_byte());
      end
    end

    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d console bytes, checked %0d result bytes, %0d delete sequences collapsed.",
             sent_count, results_checked, deletes_seen);
    if (pending_count != 0)
      $display("%0t: %0d expected result bytes never arrived", $time, pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/dkef_pkg.sv
rtl/dkef_decode.sv
rtl/dkef_burst.sv
rtl/delete_key_escape_filter.sv
dv/dkef_stream_checker.sv
dv/delete_key_escape_filter_tb.sv
